>>> src/spcr_pkg.sv
// Shared types and constants for the sphere pair contact resolver.
package spcr_pkg;

    localparam int SPCR_QDEPTH = 4;
    localparam int S_TDATA_W   = 320;
    localparam int M_TDATA_W   = 272;
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      rsum;
        logic [31:0]      ima;
        logic [31:0]      imb;
    } t_pair;

    typedef struct packed {
        t_pair       pair;
        logic [63:0] dsq;
    } t_qitem;

    typedef struct packed {
        t_pair       pair;
        logic        zero;
        logic [31:0] depth;
        logic [32:0] den;
    } t_npay;

    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      depth;
        logic             den_zero;
        logic [2:0][15:0] n;
    } t_spay;

endpackage

>>> src/sphere_pair_contact_resolve_top.sv
// Throughput: one word per cycle while the output is not stalled; the 32-stage square root
// and the 15- and 32-stage dividers are fully pipelined, and a four-entry queue sits
// between front and back end.
// Reset (synchronous, active low) clears all valid bits and the queue pointers;
// datapath registers are not reset.
module sphere_pair_contact_resolve_top #(
    parameter int QUEUE_DEPTH = spcr_pkg::SPCR_QDEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, radius_a, radius_b, inv_mass_a, inv_mass_b, zero pad
    input  logic [spcr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // normal_x, normal_y, normal_z, depth, new_a_x/y/z, new_b_x/y/z
    output logic [spcr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // hit
    output logic [0:0]                     m_axis_tuser
);
    import spcr_pkg::*;

    logic front_en, front_vld, q_full, q_empty, q_pop, back_pull;
    t_qitem front_item, q_item;

    // The front end moves as a whole whenever the queue can take its last word.
    assign front_en      = !q_full || q_pop;
    assign s_axis_tready = front_en;
    assign q_pop         = back_pull && !q_empty;

    spcr_front u_front (
        .i_clk, .i_rst_n, .i_en(front_en), .i_valid(s_axis_tvalid),
        .i_data(s_axis_tdata), .o_valid(front_vld), .o_item(front_item)
    );

    spcr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk, .i_rst_n, .i_push(front_en && front_vld), .i_item(front_item),
        .i_pop(q_pop), .o_item(q_item), .o_full(q_full), .o_empty(q_empty)
    );

    spcr_back u_back (
        .i_clk, .i_rst_n, .i_valid(!q_empty), .i_item(q_item), .o_pull(back_pull),
        .i_ready(m_axis_tready), .o_valid(m_axis_tvalid), .o_hit(m_axis_tuser[0]),
        .o_tdata(m_axis_tdata)
    );

endmodule

>>> src/spcr_front.sv
// Front end: centre deltas, squared distance and overlap classification.
module spcr_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [spcr_pkg::S_TDATA_W-1:0]     i_data,
    output logic                               o_valid,
    output spcr_pkg::t_qitem                   o_item
);
    import spcr_pkg::*;

    logic r1_vld, r2_vld, r3_vld;
    t_pair r1_pair, r2_pair;
    logic [2:0][63:0] r2_sq;
    logic [63:0] r2_rsq;
    t_qitem r3_item;

    t_pair n_pair;
    t_qitem n_item;
    logic [2:0][32:0] d;
    logic [65:0] sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i] = {i_data[32*i+31], i_data[32*i +: 32]}
                 - {i_data[96+32*i+31], i_data[96+32*i +: 32]};
            n_pair.neg[i] = d[i][32];
            n_pair.mag[i] = d[i][32] ? 32'(-d[i]) : d[i][31:0];
            n_pair.a[i]   = i_data[32*i +: 32];
            n_pair.b[i]   = i_data[96+32*i +: 32];
        end
        n_pair.hit  = 1'b0;
        n_pair.rsum = {1'b0, i_data[222:192]} + {1'b0, i_data[253:223]};
        n_pair.ima  = i_data[285:254];
        n_pair.imb  = i_data[317:286];
    end

    always_comb begin
        sum = 66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]);
        n_item.pair = r2_pair;
        // Touching exactly is not an overlap.
        n_item.pair.hit = sum < 66'(r2_rsq);
        n_item.dsq = sum[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pair <= n_pair;
            r2_pair <= r1_pair;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= r1_pair.mag[i] * r1_pair.mag[i];
            end
            r2_rsq  <= r1_pair.rsum * r1_pair.rsum;
            r3_item <= n_item;
        end
    end

    assign o_valid = r3_vld;
    assign o_item  = r3_item;

endmodule

>>> src/spcr_fifo.sv
// Short queue that decouples the front end from the back end.
module spcr_fifo #(
    parameter int DEPTH = spcr_pkg::SPCR_QDEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spcr_pkg::t_qitem i_item,
    input  logic             i_pop,
    output spcr_pkg::t_qitem o_item,
    output logic             o_full,
    output logic             o_empty
);
    import spcr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qitem r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt;

    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= n_wp;
            if (i_pop)  r_rp <= n_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

>>> src/spcr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module spcr_sqrt #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_num,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output logic [PW-1:0] o_pay
);
    logic [63:0]   w_rem  [0:32];
    logic [31:0]   w_root [0:32];
    logic          w_vld  [0:32];
    logic [PW-1:0] w_pay  [0:32];

    assign w_rem[0]  = i_num;
    assign w_root[0] = '0;
    assign w_vld[0]  = i_valid;
    assign w_pay[0]  = i_pay;

    for (genvar s = 0; s < 32; s++) begin : g_stg
        localparam int K = 31 - s;
        logic [64:0] sub;
        logic ge;
        logic r_vld;
        logic [63:0] r_rem;
        logic [31:0] r_root;
        logic [PW-1:0] r_pay;

        // Trial subtrahend is (2*root + 2^K) * 2^K with root holding only bits above K.
        always_comb begin
            sub = (65'(w_root[s]) << (K + 1)) | (65'(1) << (2 * K));
            ge  = {1'b0, w_rem[s]} >= sub;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? w_rem[s] - sub[63:0] : w_rem[s];
                r_root <= ge ? (w_root[s] | (32'(1) << K)) : w_root[s];
                r_pay  <= w_pay[s];
            end
        end

        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
        assign w_vld[s+1]  = r_vld;
        assign w_pay[s+1]  = r_pay;
    end

    assign o_valid = w_vld[32];
    assign o_root  = w_root[32];
    assign o_pay   = w_pay[32];

endmodule

>>> src/spcr_div.sv
// Pipelined restoring divider, several lanes over one shared divisor.
module spcr_div #(
    parameter int LANES = 1,
    parameter int DW    = 32,
    parameter int QW    = 16,
    parameter int PW    = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [LANES-1:0][DW+QW-1:0]      i_num,
    input  logic [DW-1:0]                    i_den,
    input  logic [PW-1:0]                    i_pay,
    output logic                             o_valid,
    output logic [LANES-1:0][QW-1:0]         o_quo,
    output logic [PW-1:0]                    o_pay
);
    localparam int W = DW + QW;

    // The quotient is known to fit in QW bits, so the remainder fits in W bits.
    logic [LANES-1:0][W-1:0]  w_rem [0:QW];
    logic [LANES-1:0][QW-1:0] w_quo [0:QW];
    logic [DW-1:0]            w_den [0:QW];
    logic                     w_vld [0:QW];
    logic [PW-1:0]            w_pay [0:QW];

    assign w_rem[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_vld[0] = i_valid;
    assign w_pay[0] = i_pay;

    for (genvar s = 0; s < QW; s++) begin : g_stg
        localparam int J = QW - 1 - s;
        logic [W-1:0] sub;
        logic [LANES-1:0][W-1:0]  n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;
        logic r_vld;
        logic [LANES-1:0][W-1:0]  r_rem;
        logic [LANES-1:0][QW-1:0] r_quo;
        logic [DW-1:0] r_den;
        logic [PW-1:0] r_pay;

        always_comb begin
            sub = W'(w_den[s]) << J;
            for (int l = 0; l < LANES; l++) begin
                if (w_rem[s][l] >= sub) begin
                    n_rem[l] = w_rem[s][l] - sub;
                    n_quo[l] = w_quo[s][l] | (QW'(1) << J);
                end else begin
                    n_rem[l] = w_rem[s][l];
                    n_quo[l] = w_quo[s][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_den <= w_den[s];
                r_pay <= w_pay[s];
            end
        end

        assign w_rem[s+1] = r_rem;
        assign w_quo[s+1] = r_quo;
        assign w_den[s+1] = r_den;
        assign w_vld[s+1] = r_vld;
        assign w_pay[s+1] = r_pay;
    end

    assign o_valid = w_vld[QW];
    assign o_quo   = w_quo[QW];
    assign o_pay   = w_pay[QW];

endmodule

>>> src/spcr_back.sv
// Back end: distance, normal, depth, mass shares and corrected centres.
module spcr_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  spcr_pkg::t_qitem               i_item,
    output logic                           o_pull,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic [spcr_pkg::M_TDATA_W-1:0] o_tdata
);
    import spcr_pkg::*;

    function automatic logic [31:0] sat32(input logic [35:0] v);
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            return v[31:0];
        end
        return v[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic en;
    logic r_ovld;
    assign en     = !r_ovld || i_ready;
    assign o_pull = en;

    // Square root of the squared distance.
    logic sq_vld;
    logic [31:0] sq_root;
    logic [$bits(t_pair)-1:0] sq_pay;

    spcr_sqrt #(.PW($bits(t_pair))) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_valid),
        .i_num(i_item.dsq), .i_pay(i_item.pair),
        .o_valid(sq_vld), .o_root(sq_root), .o_pay(sq_pay)
    );

    // Depth, normal dividends and the inverse mass sum.
    t_pair sq_pair;
    logic r1_vld;
    t_npay r1_pay;
    logic [2:0][46:0] r1_nnum;
    logic [31:0] r1_dist;

    assign sq_pair = t_pair'(sq_pay);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pay.pair  <= sq_pair;
            r1_pay.zero  <= (sq_root == '0);
            r1_pay.depth <= sq_pair.rsum - sq_root;
            r1_pay.den   <= {1'b0, sq_pair.ima} + {1'b0, sq_pair.imb};
            r1_dist      <= sq_root;
            for (int i = 0; i < 3; i++) begin
                r1_nnum[i] <= 47'({sq_pair.mag[i], 14'b0}) + 47'(sq_root >> 1);
            end
        end
    end

    logic nd_vld;
    logic [2:0][14:0] nd_quo;
    logic [$bits(t_npay)-1:0] nd_pay;

    spcr_div #(.LANES(3), .DW(32), .QW(15), .PW($bits(t_npay))) u_ndiv (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r1_vld),
        .i_num(r1_nnum), .i_den(r1_dist), .i_pay(r1_pay),
        .o_valid(nd_vld), .o_quo(nd_quo), .o_pay(nd_pay)
    );

    // Signed normal and the depth times inverse mass products.
    t_npay nd_p;
    t_spay n2_pay;
    logic [14:0] qm;
    logic r2_vld;
    t_spay r2_pay;
    logic [63:0] r2_pa, r2_pb;
    logic [32:0] r2_den;

    assign nd_p = t_npay'(nd_pay);

    always_comb begin
        n2_pay.hit      = nd_p.pair.hit;
        n2_pay.a        = nd_p.pair.a;
        n2_pay.b        = nd_p.pair.b;
        n2_pay.depth    = nd_p.depth;
        n2_pay.den_zero = (nd_p.den == '0);
        qm = '0;
        for (int i = 0; i < 3; i++) begin
            if (nd_p.zero) begin
                // Coincident centres push along +y.
                n2_pay.n[i] = (i == 1) ? {1'b0, ONE_Q14} : '0;
            end else begin
                qm = (nd_quo[i] > ONE_Q14) ? ONE_Q14 : nd_quo[i];
                n2_pay.n[i] = nd_p.pair.neg[i] ? -{1'b0, qm} : {1'b0, qm};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pay <= n2_pay;
            r2_pa  <= nd_p.depth * nd_p.pair.ima;
            r2_pb  <= nd_p.depth * nd_p.pair.imb;
            r2_den <= nd_p.den;
        end
    end

    // Share dividends with half the divisor added for rounding.
    logic r3_vld;
    t_spay r3_pay;
    logic [1:0][64:0] r3_snum;
    logic [32:0] r3_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_pay     <= r2_pay;
            r3_snum[0] <= {1'b0, r2_pa} + 65'(r2_den >> 1);
            r3_snum[1] <= {1'b0, r2_pb} + 65'(r2_den >> 1);
            r3_den     <= r2_den;
        end
    end

    logic sd_vld;
    logic [1:0][31:0] sd_quo;
    logic [$bits(t_spay)-1:0] sd_pay;

    spcr_div #(.LANES(2), .DW(33), .QW(32), .PW($bits(t_spay))) u_sdiv (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r3_vld),
        .i_num(r3_snum), .i_den(r3_den), .i_pay(r3_pay),
        .o_valid(sd_vld), .o_quo(sd_quo), .o_pay(sd_pay)
    );

    // Normal magnitude times each share.
    t_spay sd_p;
    logic [2:0][14:0] nmag;
    logic r4_vld;
    t_spay r4_pay;
    logic [2:0][46:0] r4_pa, r4_pb;

    assign sd_p = t_spay'(sd_pay);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nmag[i] = sd_p.n[i][15] ? 15'(-sd_p.n[i]) : sd_p.n[i][14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_pay <= sd_p;
            for (int i = 0; i < 3; i++) begin
                r4_pa[i] <= nmag[i] * sd_quo[0];
                r4_pb[i] <= nmag[i] * sd_quo[1];
            end
        end
    end

    // Rounded moves, saturating add, and the output register.
    logic [2:0][33:0] mva, mvb;
    logic [2:0][35:0] sa, sb;
    logic [2:0][31:0] na, nb;
    logic [2:0][15:0] nn;
    logic [31:0] ndep;
    logic [M_TDATA_W-1:0] r_odata;
    logic r_ohit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mva[i] = 34'((48'(r4_pa[i]) + 48'd8192) >> 14);
            mvb[i] = 34'((48'(r4_pb[i]) + 48'd8192) >> 14);
            sa[i] = r4_pay.n[i][15]
                  ? {{4{r4_pay.a[i][31]}}, r4_pay.a[i]} - {2'b0, mva[i]}
                  : {{4{r4_pay.a[i][31]}}, r4_pay.a[i]} + {2'b0, mva[i]};
            sb[i] = r4_pay.n[i][15]
                  ? {{4{r4_pay.b[i][31]}}, r4_pay.b[i]} + {2'b0, mvb[i]}
                  : {{4{r4_pay.b[i][31]}}, r4_pay.b[i]} - {2'b0, mvb[i]};
            if (r4_pay.hit && !r4_pay.den_zero) begin
                na[i] = sat32(sa[i]);
                nb[i] = sat32(sb[i]);
            end else begin
                na[i] = r4_pay.a[i];
                nb[i] = r4_pay.b[i];
            end
            nn[i] = r4_pay.hit ? r4_pay.n[i] : '0;
        end
        ndep = r4_pay.hit ? r4_pay.depth : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r1_vld <= sq_vld;
            r2_vld <= nd_vld;
            r3_vld <= r2_vld;
            r4_vld <= sd_vld;
            r_ovld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ohit  <= r4_pay.hit;
            r_odata <= {nb[2], nb[1], nb[0], na[2], na[1], na[0], ndep, nn[2], nn[1], nn[0]};
        end
    end

    assign o_valid = r_ovld;
    assign o_hit   = r_ohit;
    assign o_tdata = r_odata;

endmodule

>>> src/spcr_checker.sv
// Port-level checks for the sphere pair contact resolver, with its bind.
module spcr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [spcr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [spcr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser
);
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[79:0] == 80'd0)
        else $error("normal or depth nonzero without contact");

    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[79:48] != 32'd0)
        else $error("contact with zero depth");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384)
                       && ($signed(m_axis_tdata[15:0]) >= -16'sd16384))
        else $error("normal x out of unit range");

endmodule

bind sphere_pair_contact_resolve_top spcr_checker u_spcr_checker (.*);
